// ===== hw/rtl/sha256_pkg.sv =====
package sha256_pkg;

	typedef logic [31:0] word_t;

	// controller to datapath commands
	typedef struct packed {
		logic       put_byte;     // write byte into window at byte position
		logic [5:0] byte_pos;
		logic       pad_zero;     // clear words after pad position
		logic       clear_win;    // zero whole window
		logic       put_len;      // write length into words 14 and 15
		logic       start_blk;    // load working words from chain
		logic       round;        // run one round
		logic [5:0] rnd;
		logic       fold;         // add working words into chain
		logic       restart;      // reset chain and length
		logic       add_len;      // count eight bits
	} dp_cmd_t;

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LENGTH_POS = 6'd56;
	localparam logic [2:0] REG_EXTRA  = 3'd0;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== hw/rtl/sha256_dp.sv =====
module sha256_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::dp_cmd_t   cmd,
	input  logic [7:0]            byte_in,
	input  logic [31:0]           extra_bytes,
	input  logic [2:0]            out_sel,
	output logic [31:0]           out_word
);
	import sha256_pkg::*;

	word_t      win_q [16];
	word_t      hash_q [8];
	word_t      v_q [8];
	logic [63:0] len_q;

	word_t w_new, wt, t1, t2, s0, s1, w2, w15;
	logic [63:0] len_tot;
	logic [3:0]  t4;

	// schedule word for this round
	always_comb begin
		t4  = cmd.rnd[3:0];
		w2  = win_q[t4 - 4'd2];
		w15 = win_q[t4 - 4'd15];
		s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
		s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
		w_new = s1 + win_q[t4 - 4'd7] + s0 + win_q[t4];
		wt  = (cmd.rnd[5:4] != 2'd0) ? w_new : win_q[t4];
		t1  = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + K_TAB[cmd.rnd] + wt;
		t2  = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		len_tot = len_q + {29'd0, extra_bytes, 3'd0};
	end

	// message window
	always_ff @(posedge clk) begin
		if (cmd.clear_win) begin
			for (int i = 0; i < 16; i++) win_q[i] <= '0;
		end else if (cmd.round) begin
			win_q[t4] <= wt;
		end else if (cmd.put_len) begin
			win_q[14] <= len_tot[63:32];
			win_q[15] <= len_tot[31:0];
		end else if (cmd.put_byte) begin
			for (int i = 0; i < 16; i++) begin
				if (cmd.pad_zero && i > int'(cmd.byte_pos[5:2])) win_q[i] <= '0;
			end
			for (int j = 0; j < 4; j++) begin
				if (cmd.byte_pos[1:0] == 2'(j))
					win_q[cmd.byte_pos[5:2]][31-8*j -: 8] <= byte_in;
				else if (cmd.pad_zero && cmd.byte_pos[1:0] < 2'(j))
					win_q[cmd.byte_pos[5:2]][31-8*j -: 8] <= 8'd0;
			end
		end
	end

	// chain, working words and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= H_INIT[i];
				v_q[i]    <= '0;
			end
			len_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= H_INIT[i];
				len_q <= '0;
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
			end
			if (cmd.add_len) len_q <= len_q + 64'd8;
			if (cmd.start_blk) begin
				for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
			end else if (cmd.round) begin
				v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
		end
	end

	assign out_word = hash_q[out_sel];

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
module sha256_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 byte_present,
	input  logic                 end_of_message,
	output logic [7:0]           byte_sel,
	output sha256_pkg::dp_cmd_t  cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           out_idx
);
	import sha256_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_RND   = 3'd2;
	localparam logic [2:0] ST_FOLD  = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;
	localparam logic [2:0] ST_LEN   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [5:0] pos_q, rnd_q;
	logic [2:0] idx_q;
	logic       eom_q;   // padding pending after block
	logic       fin_q;   // this compression is the final one
	logic       two_q;   // length block still to come after this one
	logic [7:0] byte_q;
	logic       acc;

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_idx   = idx_q;
	assign byte_sel  = (state_q == ST_PAD) ? PAD_BYTE : byte_q;

	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.byte_pos = pos_q;
		case (state_q)
			ST_START: cmd.start_blk = 1'b1;
			ST_RND:   cmd.round = 1'b1;
			ST_FOLD:  cmd.fold = 1'b1;
			ST_PAD: begin
				cmd.put_byte = 1'b1;
				cmd.pad_zero = 1'b1;
			end
			ST_LEN:   cmd.put_len = 1'b1;
			default: ;
		endcase
		if (state_q == ST_IDLE && acc && byte_present) begin
			cmd.add_len = 1'b1;
		end
		if (state_q == ST_OUT && out_ready && idx_q == 3'd7) begin
			cmd.restart = 1'b1;
			cmd.clear_win = 1'b1;
		end
		if (state_q == ST_FOLD && two_q) cmd.clear_win = 1'b1;
	end

	// byte written straight from the port on acceptance
	assign byte_q = 8'd0;

	// sequence the block work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0; rnd_q <= '0; idx_q <= '0;
			eom_q <= 1'b0; fin_q <= 1'b0; two_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (acc) begin
					if (byte_present) pos_q <= pos_q + 6'd1;
					eom_q <= end_of_message;
					if (byte_present && pos_q == 6'd63) begin
						state_q <= ST_START;
						fin_q <= 1'b0;
					end else if (end_of_message) begin
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					two_q <= (pos_q >= LENGTH_POS);
					state_q <= (pos_q >= LENGTH_POS) ? ST_START : ST_LEN;
					fin_q <= (pos_q < LENGTH_POS);
				end
				ST_LEN: state_q <= ST_START;
				ST_START: begin
					rnd_q <= '0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (fin_q) begin
						state_q <= ST_OUT;
						idx_q <= '0;
					end else if (two_q) begin
						two_q <= 1'b0;
						fin_q <= 1'b1;
						state_q <= ST_LEN;
					end else if (eom_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						state_q <= ST_IDLE;
						pos_q <= '0;
						eom_q <= 1'b0;
						fin_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/sha256_message_hasher.sv =====
// channel | signals                                   | direction
// in      | in_valid/in_ready, msg_byte, byte_present, end_of_message | in
// out     | out_valid/out_ready, digest_word, word_index, last_word  | out
// cfg     | psel penable pwrite paddr pwdata prdata pready         | APB
// Bytes enter back to back while idle; every 64th byte starts a compression
// (load, 64 rounds of the one round unit, fold).
// The end mark adds padding and one or two compressions, then eight words.
// Input is held off while padding, compressing or while the digest is being taken.
// Reset restores the initial chain, clears counters and the length register.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sha256_pkg::*;

	dp_cmd_t    cmd, cmd_c;
	logic [7:0] byte_sel, dp_byte;
	logic [31:0] extra_q;
	logic       acc;

	assign pready = 1'b1;
	assign prdata = (paddr == {REG_EXTRA[0], 2'b00}) ? extra_q : 32'd0;

	// hold the length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) extra_q <= '0;
		else if (psel && penable && pwrite && paddr == {REG_EXTRA[0], 2'b00})
			extra_q <= pwdata;
	end

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .byte_present, .end_of_message,
		.byte_sel, .cmd(cmd_c), .out_valid, .out_ready, .out_idx(word_index)
	);

	// write accepted bytes directly at the fill position
	assign acc = in_valid && in_ready && byte_present;
	always_comb begin
		cmd = cmd_c;
		dp_byte = byte_sel;
		if (acc) begin
			cmd.put_byte = 1'b1;
			dp_byte = msg_byte;
		end
	end

	sha256_dp u_dp (
		.clk, .arst_n, .cmd, .byte_in(dp_byte), .extra_bytes(extra_q),
		.out_sel(word_index), .out_word(digest_word)
	);

	assign last_word = (word_index == 3'd7);

endmodule

// ===== hw/rtl/sha256_checker.sv =====
module sha256_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_index,
	input logic       last_word
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input open during digest");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7))) else $error("last flag");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> (out_valid &&
		word_index == $past(word_index) + 3'd1)) else $error("word order");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> word_index == 3'd0) else $error("first word");
endmodule

bind sha256_message_hasher sha256_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .word_index, .last_word
);

// ===== test/sha256_message_hasher_test.sv =====
`timescale 1ns / 100ps

module sha256_message_hasher_test;
	import sha256_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 160;
	localparam int TARGET_ITEMS = 150;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_exp_t;

	typedef struct {
		logic [7:0]  b;
		logic        present;
		logic        eom;
		bit          known;
		logic [31:0] word0;
	} vec_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  msg_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// hasher shadow state
	word_t       chain [8];
	word_t       sched [16];
	int unsigned fill;
	logic [63:0] bits_seen;
	logic [31:0] extra_bytes;

	digest_exp_t digest_q [$];
	int          errors;
	int          idle_cycles;
	bit          calm;
	int          items_sent;

	sha256_message_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.msg_byte(msg_byte), .byte_present(byte_present), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic word_t ror(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// run the 64 rounds over the window and fold into the chain
	task automatic compress();
		word_t v [8];
		word_t w2, w15, t1, t2;
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int t = 0; t < 64; t++) begin
			if (t >= 16) begin
				w2 = sched[(t - 2) & 15];
				w15 = sched[(t - 15) & 15];
				sched[t & 15] = (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10)) + sched[(t - 7) & 15]
					+ (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + sched[t & 15];
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + sched[t & 15];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic place_byte(input int unsigned pos, input logic [7:0] b);
		sched[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = b;
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			chain[i] = H_INIT[i];
		for (int i = 0; i < 16; i++)
			sched[i] = '0;
		fill = 0;
		bits_seen = '0;
	endtask

	// absorb one accepted item; queue the digest on an end mark
	task automatic absorb_item(input logic [7:0] b, input logic present, input logic eom);
		logic [63:0] len;
		digest_exp_t e;
		if (present) begin
			place_byte(fill, b);
			bits_seen += 64'd8;
			fill++;
			if (fill >= 64) begin
				compress();
				fill = 0;
			end
		end
		if (eom) begin
			place_byte(fill, PAD_BYTE);
			for (int unsigned i = fill + 1; i < 64; i++)
				place_byte(i, 8'h00);
			if (fill + 1 > LENGTH_POS) begin
				compress();
				for (int i = 0; i < 16; i++)
					sched[i] = '0;
			end
			len = bits_seen + 64'(extra_bytes) * 64'd8;
			sched[14] = len[63:32];
			sched[15] = len[31:0];
			compress();
			for (int i = 0; i < 8; i++) begin
				e.word = chain[i];
				e.idx = 3'(i);
				e.last = (i == 7);
				digest_q = {digest_q, e};
			end
			restart_message();
		end
	endtask

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	// offer one item and hold it until taken
	task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		msg_byte <= b;
		byte_present <= present;
		end_of_message <= eom;
		do @(posedge clk); while (!(in_valid && in_ready));
		absorb_item(b, present, eom);
		items_sent++;
	endtask

	// drain outstanding words, then let the block settle
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (digest_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_extra(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(REG_EXTRA * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		extra_bytes = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one random message; lengths favour the padding boundaries
	task automatic send_message();
		int len;
		int pick;
		calm = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 9);
		case (pick)
			0: len = 55;
			1: len = 56;
			2: len = 63 + $urandom_range(0, 1);
			3: len = 119 + $urandom_range(0, 1);
			default: len = $urandom_range(0, 20);
		endcase
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
		end
		// close with a bare end mark unless the last byte carried it
		if (len == 0 || !end_of_message)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// check each delivered digest word
	always @(posedge clk) begin
		digest_exp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected word %h", digest_word));
			end else begin
				e = digest_q.pop_front();
				if (digest_word !== e.word)
					flag_mismatch($sformatf("digest_word %h, want %h", digest_word, e.word));
				if (word_index !== e.idx)
					flag_mismatch($sformatf("word_index %0d, want %0d", word_index, e.idx));
				if (last_word !== e.last)
					flag_mismatch($sformatf("last_word %b, want %b", last_word, e.last));
			end
		end
	end

	// stall the result side at random
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			if (!out_ready || gap > 0) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		vec_row_t rows [13];
		rows = '{
			'{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
			'{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
			'{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
			'{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 32'h0},
			'{8'h80, 1'b1, 1'b1, 1'b0, 32'h0},
			'{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442}
		};
		errors = 0;
		items_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		msg_byte = '0;
		byte_present = 1'b0;
		end_of_message = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		extra_bytes = '0;
		restart_message();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items from reset with no extra length
		foreach (rows[i]) begin
			send_item(rows[i].b, rows[i].present, rows[i].eom);
			if (rows[i].known && digest_q[digest_q.size() - 8].word !== rows[i].word0)
				flag_mismatch($sformatf("row %0d digest head, want %h", i, rows[i].word0));
		end

		// random messages under several length offsets
		wait_quiet();
		write_extra(32'hffffffff);
		while (items_sent < TARGET_ITEMS / 3)
			send_message();
		wait_quiet();
		write_extra($urandom);
		while (items_sent < 2 * TARGET_ITEMS / 3)
			send_message();
		wait_quiet();
		write_extra(32'd1);
		while (items_sent < TARGET_ITEMS)
			send_message();

		wait_quiet();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_dp.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_message_hasher.sv
hw/rtl/sha256_checker.sv
test/sha256_message_hasher_test.sv
